// ----- sv/llch_pkg.sv -----
// Shared types and codes of the least-loaded cluster heap.
// Holds the word structs of both channels, the operation and command-kind codes
// and the default values of the top-level parameters. Depends on nothing.
package llch_pkg;

    // Default values of the top-level parameters.
    localparam int NUM_CLUSTERS_DEF = 16;
    localparam int COUNT_BITS_DEF   = 16;

    // Fixed field widths of the channel words.
    localparam int OP_W    = 2;
    localparam int CID_W   = 4;
    localparam int SIZE_W  = 16;
    localparam int NCNT_W  = 16;
    localparam int KIND_W  = 3;

    // Operation codes of an input word.
    localparam logic [OP_W-1:0] OP_ASSIGN  = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_SET     = 2'd2;

    // Command kinds handed from the front end to the heap engine.
    localparam logic [KIND_W-1:0] K_ASSIGN  = 3'd0;
    localparam logic [KIND_W-1:0] K_RELEASE = 3'd1;
    localparam logic [KIND_W-1:0] K_SET     = 3'd2;
    localparam logic [KIND_W-1:0] K_PEEK    = 3'd3;
    localparam logic [KIND_W-1:0] K_REJECT  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CID_W-1:0]  cluster_sel;
        logic [SIZE_W-1:0] size_value;
    } in_item_t;

    typedef struct packed {
        logic [CID_W-1:0]  touched_cluster;
        logic [NCNT_W-1:0] new_count;
        logic [CID_W-1:0]  min_cluster;
        logic              error_flag;
    } out_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CID_W-1:0]  cluster_sel;
        logic [SIZE_W-1:0] size_value;
    } cmd_t;

endpackage

// ----- sv/llch_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the heap slots and the cluster-to-slot map. No dependencies.
module llch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/llch_front.sv -----
// Front end of the least-loaded cluster heap: takes input words, sorts them
// into command kinds and buffers them in a two-entry queue. Uses llch_pkg.
module llch_front #(
    parameter int NUM_CLUSTERS = llch_pkg::NUM_CLUSTERS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  llch_pkg::in_item_t s_data,
    output logic               q_valid,
    output llch_pkg::cmd_t     q_cmd,
    input  logic               q_pop
);

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    llch_pkg::cmd_t q_mem_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    llch_pkg::cmd_t cls_cmd;
    logic           push;
    logic           id_ok;

    // An id at or above the cluster count is refused for every operation
    // except assign, which never looks at the id.
    assign id_ok = {28'd0, s_data.cluster_sel} < 32'(NUM_CLUSTERS);

    always_comb begin
        cls_cmd.cluster_sel = s_data.cluster_sel;
        cls_cmd.size_value  = s_data.size_value;
        if (s_data.operation == llch_pkg::OP_ASSIGN) begin
            cls_cmd.kind = llch_pkg::K_ASSIGN;
        end else if (!id_ok) begin
            cls_cmd.kind = llch_pkg::K_REJECT;
        end else begin
            case (s_data.operation)
                llch_pkg::OP_RELEASE: cls_cmd.kind = llch_pkg::K_RELEASE;
                llch_pkg::OP_SET:     cls_cmd.kind = llch_pkg::K_SET;
                default:              cls_cmd.kind = llch_pkg::K_PEEK;
            endcase
        end
    end

    assign s_ready = cnt_reg != QCW'(QDEPTH);
    assign push    = s_valid && s_ready;
    assign q_valid = cnt_reg != '0;
    assign q_cmd   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCW'(push) - QCW'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

// ----- sv/llch_back.sv -----
// Heap engine of the least-loaded cluster heap: runs each command against the
// heap and slot-map RAMs and drives the result register. Uses llch_pkg, llch_ram.
module llch_back #(
    parameter int NUM_CLUSTERS = llch_pkg::NUM_CLUSTERS_DEF,
    parameter int COUNT_BITS   = llch_pkg::COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  llch_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output llch_pkg::out_item_t m_data
);

    localparam int CL  = $clog2(NUM_CLUSTERS);
    localparam int AW1 = CL + 1;
    localparam int HW  = CL + COUNT_BITS;
    localparam int IW  = CL > llch_pkg::CID_W ? CL : llch_pkg::CID_W;
    localparam int SW  = COUNT_BITS > llch_pkg::SIZE_W ? COUNT_BITS : llch_pkg::SIZE_W;
    localparam logic [AW1-1:0]        N1      = AW1'(NUM_CLUSTERS);
    localparam logic [CL-1:0]         LAST    = CL'(NUM_CLUSTERS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SLOT   = 4'd2;
    localparam logic [3:0] ST_CNT    = 4'd3;
    localparam logic [3:0] ST_DOWN_L = 4'd4;
    localparam logic [3:0] ST_DOWN_R = 4'd5;
    localparam logic [3:0] ST_UP_P   = 4'd6;
    localparam logic [3:0] ST_FINAL  = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    function automatic logic [llch_pkg::CID_W-1:0] id4(input logic [CL-1:0] v);
        logic [IW-1:0] w;
        w = IW'(v);
        return w[llch_pkg::CID_W-1:0];
    endfunction

    function automatic logic [llch_pkg::NCNT_W-1:0] cnt16(input logic [COUNT_BITS-1:0] v);
        logic [SW-1:0] w;
        w = SW'(v);
        return w[llch_pkg::NCNT_W-1:0];
    endfunction

    logic [3:0]            state_reg, state_next;
    logic [CL-1:0]         clr_idx_reg, clr_idx_next;
    logic [llch_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [CL-1:0]         cl_reg, cl_next;
    logic [COUNT_BITS-1:0] val_reg, val_next;
    logic [COUNT_BITS-1:0] new_reg, new_next;
    logic [CL-1:0]         s_reg, s_next;
    logic [CL-1:0]         c_reg, c_next;
    logic [HW-1:0]         lft_reg, lft_next;
    logic [CL-1:0]         root_id_reg, root_id_next;
    logic [COUNT_BITS-1:0] root_cnt_reg, root_cnt_next;
    llch_pkg::out_item_t   res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    llch_pkg::out_item_t   m_data_reg, m_data_next;

    logic          heap_we, slot_we;
    logic [CL-1:0] heap_waddr, heap_raddr, slot_waddr, slot_raddr;
    logic [HW-1:0] heap_wdata, heap_rdata;
    logic [CL-1:0] slot_wdata, slot_rdata;

    llch_ram #(.WIDTH(HW), .DEPTH(NUM_CLUSTERS)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    llch_ram #(.WIDTH(CL), .DEPTH(NUM_CLUSTERS)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    always_comb begin
        logic [IW-1:0]         cid_w;
        logic [CL-1:0]         cmd_cl;
        logic [SW-1:0]         sz_w;
        logic [COUNT_BITS-1:0] sat;
        logic [COUNT_BITS-1:0] old;
        logic [COUNT_BITS-1:0] upd;
        logic                  go_update;
        logic                  do_down;
        logic [HW-1:0]         pick;
        logic [CL-1:0]         pick_idx;
        logic [AW1-1:0]        nc;
        logic [CL-1:0]         par;

        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        kind_next     = kind_reg;
        cl_next       = cl_reg;
        val_next      = val_reg;
        new_next      = new_reg;
        s_next        = s_reg;
        c_next        = c_reg;
        lft_next      = lft_reg;
        root_id_next  = root_id_reg;
        root_cnt_next = root_cnt_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        heap_we    = 1'b0;
        heap_waddr = s_reg;
        heap_wdata = {cl_reg, new_reg};
        heap_raddr = c_reg;
        slot_we    = 1'b0;
        slot_waddr = cl_reg;
        slot_wdata = s_reg;
        q_pop      = 1'b0;

        cid_w      = IW'(q_cmd.cluster_sel);
        cmd_cl     = cid_w[CL-1:0];
        slot_raddr = cmd_cl;
        sz_w       = SW'(q_cmd.size_value);
        sat        = (sz_w > SW'(CNT_MAX)) ? CNT_MAX : sz_w[COUNT_BITS-1:0];
        old        = heap_rdata[COUNT_BITS-1:0];
        upd        = '0;
        go_update  = 1'b0;
        do_down    = 1'b0;
        pick       = heap_rdata;
        pick_idx   = c_reg;
        nc         = '0;
        par        = '0;

        case (state_reg)
            ST_CLEAR: begin
                heap_we    = 1'b1;
                heap_waddr = clr_idx_reg;
                heap_wdata = {clr_idx_reg, {COUNT_BITS{1'b0}}};
                slot_we    = 1'b1;
                slot_waddr = clr_idx_reg;
                slot_wdata = clr_idx_reg;
                if (clr_idx_reg == LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    kind_next = q_cmd.kind;
                    cl_next   = cmd_cl;
                    val_next  = sat;
                    case (q_cmd.kind)
                        llch_pkg::K_ASSIGN: begin
                            cl_next = root_id_reg;
                            s_next  = '0;
                            if (root_cnt_reg == CNT_MAX) begin
                                res_next = '{id4(root_id_reg), cnt16(root_cnt_reg),
                                             id4(root_id_reg), 1'b1};
                                state_next = ST_EMIT;
                            end else begin
                                new_next   = root_cnt_reg + 1'b1;
                                c_next     = CL'(1);
                                heap_raddr = CL'(1);
                                state_next = ST_DOWN_L;
                            end
                        end
                        llch_pkg::K_REJECT: begin
                            res_next = '{q_cmd.cluster_sel, {llch_pkg::NCNT_W{1'b0}},
                                         id4(root_id_reg), 1'b1};
                            state_next = ST_EMIT;
                        end
                        default: begin
                            state_next = ST_SLOT;
                        end
                    endcase
                end
            end
            ST_SLOT: begin
                s_next     = slot_rdata;
                heap_raddr = slot_rdata;
                state_next = ST_CNT;
            end
            ST_CNT: begin
                case (kind_reg)
                    llch_pkg::K_PEEK: begin
                        res_next   = '{id4(cl_reg), cnt16(old), id4(root_id_reg), 1'b1};
                        state_next = ST_EMIT;
                    end
                    llch_pkg::K_RELEASE: begin
                        if (old == '0) begin
                            res_next = '{id4(cl_reg), {llch_pkg::NCNT_W{1'b0}},
                                         id4(root_id_reg), 1'b1};
                            state_next = ST_EMIT;
                        end else begin
                            upd       = old - 1'b1;
                            go_update = 1'b1;
                        end
                    end
                    default: begin
                        upd       = val_reg;
                        go_update = 1'b1;
                    end
                endcase
                if (go_update) begin
                    new_next = upd;
                    if (upd > old) begin
                        nc = {s_reg, 1'b1};
                        if (nc < N1) begin
                            c_next     = nc[CL-1:0];
                            heap_raddr = nc[CL-1:0];
                            state_next = ST_DOWN_L;
                        end else begin
                            state_next = ST_FINAL;
                        end
                    end else if (s_reg == '0) begin
                        state_next = ST_FINAL;
                    end else begin
                        par        = (s_reg - 1'b1) >> 1;
                        c_next     = par;
                        heap_raddr = par;
                        state_next = ST_UP_P;
                    end
                end
            end
            ST_DOWN_L: begin
                // Read data is the left child; fetch the right one if it exists.
                lft_next = heap_rdata;
                nc       = AW1'(c_reg) + 1'b1;
                if (nc < N1) begin
                    heap_raddr = nc[CL-1:0];
                    state_next = ST_DOWN_R;
                end else begin
                    pick     = heap_rdata;
                    pick_idx = c_reg;
                    do_down  = 1'b1;
                end
            end
            ST_DOWN_R: begin
                // The right child wins only on a strictly smaller count.
                if (heap_rdata[COUNT_BITS-1:0] < lft_reg[COUNT_BITS-1:0]) begin
                    pick     = heap_rdata;
                    pick_idx = c_reg + 1'b1;
                end else begin
                    pick     = lft_reg;
                    pick_idx = c_reg;
                end
                do_down = 1'b1;
            end
            ST_UP_P: begin
                if (new_reg < heap_rdata[COUNT_BITS-1:0]) begin
                    heap_we    = 1'b1;
                    heap_waddr = s_reg;
                    heap_wdata = heap_rdata;
                    slot_we    = 1'b1;
                    slot_waddr = heap_rdata[HW-1:COUNT_BITS];
                    slot_wdata = s_reg;
                    s_next     = c_reg;
                    if (c_reg == '0) begin
                        state_next = ST_FINAL;
                    end else begin
                        par        = (c_reg - 1'b1) >> 1;
                        c_next     = par;
                        heap_raddr = par;
                    end
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                heap_we    = 1'b1;
                slot_we    = 1'b1;
                if (s_reg == '0) begin
                    root_id_next  = cl_reg;
                    root_cnt_next = new_reg;
                    res_next = '{id4(cl_reg), cnt16(new_reg), id4(cl_reg), 1'b0};
                end else begin
                    res_next = '{id4(cl_reg), cnt16(new_reg), id4(root_id_reg), 1'b0};
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // One sift-down step: the smaller child moves up into the hole when the
        // moving entry is strictly larger than it.
        if (do_down) begin
            if (new_reg > pick[COUNT_BITS-1:0]) begin
                heap_we    = 1'b1;
                heap_waddr = s_reg;
                heap_wdata = pick;
                slot_we    = 1'b1;
                slot_waddr = pick[HW-1:COUNT_BITS];
                slot_wdata = s_reg;
                if (s_reg == '0) begin
                    root_id_next  = pick[HW-1:COUNT_BITS];
                    root_cnt_next = pick[COUNT_BITS-1:0];
                end
                s_next = pick_idx;
                nc     = {pick_idx, 1'b1};
                if (nc < N1) begin
                    c_next     = nc[CL-1:0];
                    heap_raddr = nc[CL-1:0];
                    state_next = ST_DOWN_L;
                end else begin
                    state_next = ST_FINAL;
                end
            end else begin
                state_next = ST_FINAL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            root_id_reg  <= '0;
            root_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            root_id_reg  <= root_id_next;
            root_cnt_reg <= root_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        cl_reg     <= cl_next;
        val_reg    <= val_next;
        new_reg    <= new_next;
        s_reg      <= s_next;
        c_reg      <= c_next;
        lft_reg    <= lft_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sv/least_loaded_cluster_heap.sv -----
// Top level of the least-loaded cluster heap: joins the front end and the heap engine.
// Depends on llch_pkg, llch_front, llch_back (and llch_ram through the engine).

// The block keeps an indexed binary min-heap of member counts, one entry per
// cluster, plus a map from cluster to heap slot, both held in RAMs. A word on
// the input channel asks for assign (the cluster at the root gains one member),
// release (a named cluster loses one) or set (a named cluster gets a given
// count, saturated to the count width). Every input word yields exactly one
// result word: the cluster touched, its new count, the cluster at the root
// afterwards and an error flag, which is raised when a release finds a zero
// count, an assign finds the root already at the maximum count, the cluster id
// is out of range or the operation code is unused; the heap is then left as it
// was. After reset the block first writes the initial heap into its RAMs; the
// front end still takes up to two input words in that time and holds them in
// its queue. The front end classifies words into a two-entry queue, so input
// words are still taken while the engine works or a result waits, and a word
// is registered in the queue before the engine sees it. The engine handles one
// word at a time. An assign sifts the root entry down, and each sift-down level
// reads the two children through the single read port of the heap RAM; a
// release, or a set that lowers a count, looks up the slot map and the count
// and then sifts up, one parent per level; a set that raises a count sifts
// down in the same way as an assign. A refused word needs no lookup when it is
// an assign at the maximum count or an id out of range, and goes through the
// slot-map and count lookups otherwise.
module least_loaded_cluster_heap #(
    parameter int NUM_CLUSTERS = llch_pkg::NUM_CLUSTERS_DEF,
    parameter int COUNT_BITS   = llch_pkg::COUNT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  llch_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output llch_pkg::out_item_t m_data
);

    // Command queue between the front end and the engine.
    logic           q_valid;
    logic           q_pop;
    llch_pkg::cmd_t q_cmd;

    llch_front #(
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // The engine owns the heap RAMs and the output register.
    llch_back #(
        .NUM_CLUSTERS (NUM_CLUSTERS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
